// File: rtl/esfd_pkg.sv
// Shared constants, types and escape-sequence tables for the sample frame deframer.
`timescale 1ns / 1ps
`default_nettype none
package esfd_pkg;

   localparam int MESSAGE_CAPACITY_DEF = 64;
   localparam int ESCAPE_LENGTH        = 6;
   localparam int MAX_CHANNELS         = 8;

   localparam int BYTE_W    = 8;
   localparam int COUNT_W   = 4;
   localparam int CHANNEL_W = 3;
   localparam int SAMPLE_W  = 21;
   localparam int MATCH_W   = 3;
   localparam int HALF_W    = 7;

   localparam logic [COUNT_W-1:0] CHANNEL_COUNT_RESET = 4'd2;

   typedef enum logic [1:0] {
      KIND_SAMPLE  = 2'd0,
      KIND_MESSAGE = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   // start sequence 255,255,1,1,128,255
   function automatic logic [BYTE_W-1:0] start_byte(input logic [MATCH_W-1:0] idx);
      case (idx)
         3'd0:    start_byte = 8'd255;
         3'd1:    start_byte = 8'd255;
         3'd2:    start_byte = 8'd1;
         3'd3:    start_byte = 8'd1;
         3'd4:    start_byte = 8'd128;
         3'd5:    start_byte = 8'd255;
         default: start_byte = 8'd0;
      endcase
   endfunction

   // end sequence 255,255,1,1,129,255
   function automatic logic [BYTE_W-1:0] end_byte(input logic [MATCH_W-1:0] idx);
      case (idx)
         3'd0:    end_byte = 8'd255;
         3'd1:    end_byte = 8'd255;
         3'd2:    end_byte = 8'd1;
         3'd3:    end_byte = 8'd1;
         3'd4:    end_byte = 8'd129;
         3'd5:    end_byte = 8'd255;
         default: end_byte = 8'd0;
      endcase
   endfunction

endpackage
`default_nettype wire

// File: rtl/escaped_sample_frame_deframer_top.sv
// Top level: escape matcher, held-byte replay and sample frame decoder.
`timescale 1ns / 1ps
`default_nettype none
//
//  channel | ports                                  | direction | word
//  --------+----------------------------------------+-----------+--------------------------
//  req     | req_valid, req_stall, req_data_byte    | in        | one received byte
//  rsp     | rsp_valid, rsp_stall, rsp_kind, ...    | out       | sample, message byte, error
//  csr     | csr_wr_en, csr_wr_data                 | in        | channel_count register
//
//  One word per cycle unless stalled: a byte goes into the input register, one pass
//  of logic decides it and loads the result register while the next byte is taken.
//  A start-sequence mismatch after m matched bytes replays the held bytes
//  through the frame decoder, one per cycle while no stalled result holds it:
//  that word holds the input register until it is decoded itself, and it can
//  give up to m+1 results. A stalled result holds the result register; words
//  that give no result still drain past it. Synchronous reset clears all control state.
//
module escaped_sample_frame_deframer_top #(
   parameter int MESSAGE_CAPACITY = esfd_pkg::MESSAGE_CAPACITY_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_wr_en,
   input  wire logic [esfd_pkg::COUNT_W-1:0]         csr_wr_data,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [esfd_pkg::BYTE_W-1:0]          req_data_byte,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [1:0]                                rsp_kind,
   output logic [esfd_pkg::CHANNEL_W-1:0]            rsp_channel,
   output logic signed [esfd_pkg::SAMPLE_W-1:0]      rsp_sample,
   output logic [esfd_pkg::BYTE_W-1:0]               rsp_message_byte,
   output logic                                      rsp_last
);
   import esfd_pkg::*;

   localparam int CountW = $clog2(MESSAGE_CAPACITY + 1);
   localparam logic [CountW-1:0] Capacity = CountW'(MESSAGE_CAPACITY);
   localparam logic [MATCH_W-1:0] EscLen  = MATCH_W'(ESCAPE_LENGTH);
   localparam logic [COUNT_W-1:0] MaxChan = COUNT_W'(MAX_CHANNELS);

   typedef enum logic [1:0] {
      PHASE_WAIT = 2'd0,
      PHASE_LOW  = 2'd1,
      PHASE_HIGH = 2'd2
   } phase_type;

   // configuration
   logic [COUNT_W-1:0]   chan_count_ff;

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]    in_byte_ff;

   // escape and message state
   logic                 in_message_ff, in_message_in;
   logic [MATCH_W-1:0]   match_count_ff, match_count_in;
   logic [MATCH_W-1:0]   rep_ff, rep_in;
   logic [CountW-1:0]    msg_count_ff, msg_count_in;

   // frame decoder state
   phase_type            phase_ff, phase_in;
   logic [CHANNEL_W-1:0] chan_ff, chan_in;
   logic [HALF_W-1:0]    high_ff, high_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   kind_type             kind_ff, kind_in;
   logic [CHANNEL_W-1:0] rchan_ff, rchan_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [BYTE_W-1:0]    mbyte_ff, mbyte_in;
   logic                 last_ff, last_in;

   // step control
   logic                 produce, consume, decode_en, fire, can_write, accept;

   // decoder outputs
   logic [BYTE_W-1:0]    dec_byte;
   logic                 dec_has, dec_last, frame_end;
   kind_type             dec_kind;
   logic [CHANNEL_W-1:0] dec_chan;
   logic signed [SAMPLE_W-1:0] dec_sample;
   phase_type            dec_phase;
   logic [CHANNEL_W-1:0] dec_chan_next;
   logic [HALF_W-1:0]    dec_high;
   logic [COUNT_W-1:0]   active;
   logic [2*HALF_W-1:0]  raw;
   logic signed [2*HALF_W:0]   centered;
   logic signed [SAMPLE_W-1:0] centered_ext;

   // held bytes replay first, the current byte last
   assign dec_byte = (rep_ff < match_count_ff) ? start_byte(rep_ff) : in_byte_ff;

   // channel_count clamp: 0 acts as 1, above MAX_CHANNELS acts as MAX_CHANNELS
   always_comb begin
      if (chan_count_ff == '0) begin
         active = COUNT_W'(1);
      end else if (chan_count_ff > MaxChan) begin
         active = MaxChan;
      end else begin
         active = chan_count_ff;
      end
   end

   // scaled sample: (v - 512) * 62, wraps to 21 bits
   assign raw          = {high_ff, dec_byte[HALF_W-1:0]};
   assign centered     = $signed({1'b0, raw}) - (2*HALF_W+1)'(512);
   assign centered_ext = SAMPLE_W'(centered);
   assign dec_sample   = SAMPLE_W'(centered_ext * SAMPLE_W'(62));
   assign frame_end    = ({1'b0, chan_ff} + COUNT_W'(1)) >= active;

   // one decoder step
   always_comb begin
      dec_has       = 1'b0;
      dec_kind      = KIND_SAMPLE;
      dec_chan      = chan_ff;
      dec_last      = 1'b0;
      dec_phase     = phase_ff;
      dec_chan_next = chan_ff;
      dec_high      = high_ff;
      case (phase_ff)
         PHASE_LOW: begin
            if (dec_byte[BYTE_W-1]) begin
               // high-bit byte in a low slot: error, resync on this byte
               dec_has       = 1'b1;
               dec_kind      = KIND_ERROR;
               dec_high      = dec_byte[HALF_W-1:0];
               dec_chan_next = '0;
               dec_phase     = PHASE_LOW;
            end else begin
               dec_has  = 1'b1;
               dec_kind = KIND_SAMPLE;
               dec_last = frame_end;
               if (frame_end) begin
                  dec_phase = PHASE_WAIT;
               end else begin
                  dec_chan_next = chan_ff + CHANNEL_W'(1);
                  dec_phase     = PHASE_HIGH;
               end
            end
         end
         PHASE_HIGH: begin
            dec_high  = dec_byte[HALF_W-1:0];
            dec_phase = PHASE_LOW;
            if (dec_byte[BYTE_W-1]) begin
               dec_chan_next = '0;
            end
         end
         default: begin
            if (dec_byte[BYTE_W-1]) begin
               dec_high      = dec_byte[HALF_W-1:0];
               dec_chan_next = '0;
               dec_phase     = PHASE_LOW;
            end
         end
      endcase
   end

   // escape matching, message pass-through and replay sequencing
   always_comb begin
      produce        = 1'b0;
      consume        = 1'b0;
      decode_en      = 1'b0;
      in_message_in  = in_message_ff;
      match_count_in = match_count_ff;
      rep_in         = rep_ff;
      msg_count_in   = msg_count_ff;
      kind_in        = dec_kind;
      rchan_in       = dec_chan;
      sample_in      = (dec_kind == KIND_SAMPLE) ? dec_sample : '0;
      mbyte_in       = '0;
      last_in        = dec_last;
      if (in_valid_ff) begin
         if (in_message_ff) begin
            produce      = 1'b1;
            consume      = 1'b1;
            msg_count_in = msg_count_ff + CountW'(1);
            kind_in      = KIND_MESSAGE;
            rchan_in     = '0;
            sample_in    = '0;
            mbyte_in     = in_byte_ff;
            last_in      = 1'b0;
            // capacity test comes before the end match
            if (msg_count_in >= Capacity) begin
               last_in = 1'b1;
            end else if (match_count_ff < EscLen && end_byte(match_count_ff) == in_byte_ff) begin
               match_count_in = match_count_ff + MATCH_W'(1);
               last_in        = (match_count_in == EscLen);
            end else begin
               match_count_in = '0;
            end
            if (last_in) begin
               in_message_in  = 1'b0;
               match_count_in = '0;
            end
         end else if (match_count_ff < EscLen && start_byte(match_count_ff) == in_byte_ff) begin
            consume        = 1'b1;
            match_count_in = match_count_ff + MATCH_W'(1);
            if (match_count_in == EscLen) begin
               in_message_in  = 1'b1;
               match_count_in = '0;
               msg_count_in   = '0;
            end
         end else begin
            // mismatch: replay held bytes, then decode this byte
            decode_en = 1'b1;
            produce   = dec_has;
            if (rep_ff < match_count_ff) begin
               rep_in = rep_ff + MATCH_W'(1);
            end else begin
               consume        = 1'b1;
               rep_in         = '0;
               match_count_in = '0;
            end
         end
      end
   end

   assign can_write    = !rsp_valid_ff || !rsp_stall;
   assign fire         = in_valid_ff && (can_write || !produce);
   assign req_stall    = in_valid_ff && !(fire && consume);
   assign accept       = req_valid && !req_stall;
   assign in_valid_in  = accept || (in_valid_ff && !(fire && consume));
   assign rsp_valid_in = (rsp_valid_ff && rsp_stall) || (fire && produce);

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_count_ff  <= CHANNEL_COUNT_RESET;
         in_valid_ff    <= 1'b0;
         in_message_ff  <= 1'b0;
         match_count_ff <= '0;
         rep_ff         <= '0;
         msg_count_ff   <= '0;
         phase_ff       <= PHASE_WAIT;
         chan_ff        <= '0;
         high_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            chan_count_ff <= csr_wr_data;
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            in_message_ff  <= in_message_in;
            match_count_ff <= match_count_in;
            rep_ff         <= rep_in;
            msg_count_ff   <= msg_count_in;
         end
         if (fire && decode_en) begin
            phase_ff <= dec_phase;
            chan_ff  <= dec_chan_next;
            high_ff  <= dec_high;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_data_byte;
      end
      if (fire && produce) begin
         kind_ff   <= kind_in;
         rchan_ff  <= rchan_in;
         sample_ff <= sample_in;
         mbyte_ff  <= mbyte_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_channel      = rchan_ff;
   assign rsp_sample       = sample_ff;
   assign rsp_message_byte = mbyte_ff;
   assign rsp_last         = last_ff;

   // match never rests at a full sequence
   assert property (@(posedge clock) disable iff (reset) match_count_ff < EscLen)
      else $error("match count reached escape length");

   // replay pointer stays within the held bytes, and only outside a message
   assert property (@(posedge clock) disable iff (reset)
      rep_ff <= match_count_ff && (!in_message_ff || rep_ff == '0))
      else $error("replay pointer out of range");

   // message count stays below capacity while in a message
   assert property (@(posedge clock) disable iff (reset)
      in_message_ff |-> msg_count_ff < Capacity)
      else $error("message count past capacity");

   // input word held while replay still has bytes to go
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !in_message_ff && rep_ff < match_count_ff && fire && decode_en)
      |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input word dropped during replay");

   // frame errors carry no sample and no last flag
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_ERROR) |-> (rsp_sample == '0 && !rsp_last))
      else $error("frame error with payload");

endmodule
`default_nettype wire
